// ===== rtl/gbn_pkg.sv =====
package gbn_pkg;

    localparam int MAX_BOXES_DEF  = 256;
    localparam int CLASS_BITS_DEF = 8;
    localparam int FIFO_DEPTH     = 4;
    localparam int RESULT_CAP     = 64;

    localparam logic [15:0] THR_RESET      = 16'd39322;
    localparam logic [6:0]  MAX_KEPT_RESET = 7'd30;

    typedef enum logic {
        CFG_IOU_THR  = 1'b0,
        CFG_MAX_KEPT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [15:0] box_x;
        logic signed [15:0] box_y;
        logic [15:0]        box_width;
        logic [15:0]        box_height;
        logic [15:0]        score;
        logic [7:0]         class_id;
        logic               frame_end;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] kept_x;
        logic signed [15:0] kept_y;
        logic [15:0]        kept_width;
        logic [15:0]        kept_height;
        logic [15:0]        kept_score;
        logic [7:0]         kept_class;
        logic               run_end;
        logic               overflow;
    } t_out_item;

    // one queued request: the box and whether the store was already full
    typedef struct packed {
        logic     drop;
        t_in_item item;
    } t_cmd;

    typedef struct packed {
        logic        we;
        t_cfg_idx    idx;
        logic [15:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        w;
        logic [15:0]        h;
        logic [15:0]        score;
    } t_box;

endpackage

// ===== rtl/greedy_box_nms.sv =====
// Channel  | Valid        | Stall        | Payload
// request  | i_in_valid   | o_in_stall   | i_in_data  (t_in_item, one box)
// result   | o_out_valid  | i_out_stall  | o_out_data (t_out_item, one kept box)
// config   | i_cfg_we     | none         | i_cfg_idx, i_cfg_data
//
// Boxes enter at one per cycle while the queue has room, into a four-deep queue, drained one per cycle while idle.
// A frame runs one IoU pipeline that sweeps all n stored boxes to find the first box,
// then sweeps once more for each kept box.
// Reset (synchronous, active low) clears control state and marks, loads config defaults.
// The front takes requests during a frame until the queue fills; a stalled result holds
// the back end in its emit step and so delays the end of the frame.
module greedy_box_nms
    import gbn_pkg::*;
#(
    parameter int MAX_BOXES  = MAX_BOXES_DEF,
    parameter int CLASS_BITS = CLASS_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_in_item    i_in_data,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output t_out_item   o_out_data,
    input  logic        i_out_stall,
    input  logic        i_cfg_we,
    input  t_cfg_idx    i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    logic    push, pop, empty, full;
    t_cmd    push_cmd, head_cmd;
    t_cfg_wr cfg;

    assign cfg = '{we: i_cfg_we, idx: i_cfg_idx, data: i_cfg_data};

    // classify requests: tag the ones that find the store full
    gbn_front #(
        .MAX_BOXES (MAX_BOXES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_stall (o_in_stall),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    // hold requests while the back end works on a frame
    gbn_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_empty (empty),
        .o_full  (full)
    );

    // store boxes, then run the suppression sweeps and emit kept boxes
    gbn_back #(
        .MAX_BOXES  (MAX_BOXES),
        .CLASS_BITS (CLASS_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_cmd   (head_cmd),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

endmodule

// ===== rtl/gbn_front.sv =====
module gbn_front
    import gbn_pkg::*;
#(
    parameter int MAX_BOXES = MAX_BOXES_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_data,
    output logic     o_stall,
    input  logic     i_full,
    output logic     o_push,
    output t_cmd     o_cmd
);

    localparam int CW = $clog2(MAX_BOXES + 1);

    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;
    logic          store_full;

    assign store_full = (r_cnt == CW'(MAX_BOXES));
    assign o_stall    = i_full;
    assign o_push     = i_valid && !i_full;
    assign o_cmd.drop = store_full;
    assign o_cmd.item = i_data;

    // track the fill level of the frame so a full store marks the request as dropped
    always_comb begin
        n_cnt = r_cnt;
        if (o_push) begin
            if (i_data.frame_end) begin
                n_cnt = '0;
            end else if (!store_full) begin
                n_cnt = r_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== rtl/gbn_fifo.sv =====
module gbn_fifo
    import gbn_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty,
    output logic o_full
);

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int NW = $clog2(FIFO_DEPTH + 1);

    t_cmd          r_mem [FIFO_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [NW-1:0] r_cnt;
    logic          do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == NW'(FIFO_DEPTH));
    assign o_cmd   = r_mem[r_rp];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + NW'(1);
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - NW'(1);
            end
        end
    end

endmodule

// ===== rtl/gbn_back.sv =====
module gbn_back
    import gbn_pkg::*;
#(
    parameter int MAX_BOXES  = MAX_BOXES_DEF,
    parameter int CLASS_BITS = CLASS_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg_wr   i_cfg,
    input  t_cmd      i_cmd,
    input  logic      i_empty,
    output logic      o_pop,
    output logic      o_valid,
    output t_out_item o_data,
    input  logic      i_stall
);

    localparam int IW  = $clog2(MAX_BOXES);
    localparam int CW  = $clog2(MAX_BOXES + 1);
    localparam int NST = 6;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_NEXT = 5'b00100,
        S_EMIT = 5'b01000,
        S_AREA = 5'b10000
    } t_state;

    t_state r_state;

    logic [15:0] r_thr;
    logic [6:0]  r_max_kept;
    logic [6:0]  lim;

    // box stores
    t_box            r_cmem [MAX_BOXES];
    logic [CLASS_BITS-1:0] r_smem [MAX_BOXES];
    t_box            r_rd_box;
    logic [CLASS_BITS-1:0] r_rd_cls;

    logic [CW-1:0]        r_n;
    logic                 r_ovf;
    logic [MAX_BOXES-1:0] r_mark;
    logic [CW-1:0]        r_j;
    logic [6:0]           r_kept;
    logic                 r_have_ref;
    logic                 r_run_end;

    t_box                  r_ref_box;
    logic [CLASS_BITS-1:0] r_ref_cls;
    logic [31:0]           r_ref_area;

    t_box                  r_best_box;
    logic [CLASS_BITS-1:0] r_best_cls;
    logic [IW-1:0]         r_best_idx;
    logic                  r_best_found;

    logic                  r_pv   [NST];
    logic [IW-1:0]         r_pidx [NST];
    t_box                  r_pbox [1:NST-1];
    logic [CLASS_BITS-1:0] r_pcls [1:NST-1];

    logic signed [17:0] r_x1, r_x2, r_y1, r_y2;
    logic [15:0]        r_iw, r_ih;
    logic [31:0]        r_inter3, r_ab3, r_inter4, r_inter5;
    logic [32:0]        r_uni4;
    logic [48:0]        r_rhs5;
    logic               r_uzero5;

    t_out_item r_out;
    logic      r_out_v;

    logic                  wr_en;
    logic [CLASS_BITS-1:0] in_cls;
    t_box                  in_box;
    logic                  issue;
    logic                  pipe_busy;
    logic                  out_free;
    logic signed [17:0]    ax2, bx2, ay2, by2, bx, by;
    logic signed [18:0]    dx, dy;
    logic                  d_v, d_mark, d_sup;
    logic [IW-1:0]         d_idx;
    logic [48:0]           lhs;

    assign lim = (r_max_kept == '0) ? 7'd1 :
                 (r_max_kept > 7'(RESULT_CAP)) ? 7'(RESULT_CAP) : r_max_kept;

    assign o_pop  = (r_state == S_IDLE) && !i_empty;
    assign wr_en  = o_pop && !i_cmd.drop;
    assign in_cls = 16'(i_cmd.item.class_id) >> 0 == 16'(i_cmd.item.class_id)
                    ? CLASS_BITS'(16'(i_cmd.item.class_id)) : '0;
    assign in_box = '{x: i_cmd.item.box_x, y: i_cmd.item.box_y,
                      w: i_cmd.item.box_width, h: i_cmd.item.box_height,
                      score: i_cmd.item.score};

    assign issue     = (r_state == S_SCAN) && (r_j < r_n);
    assign out_free  = !r_out_v || !i_stall;
    assign o_valid   = r_out_v;
    assign o_data    = r_out;

    always_comb begin
        pipe_busy = 1'b0;
        for (int k = 0; k < NST; k++) begin
            pipe_busy = pipe_busy | r_pv[k];
        end
    end

    // stage 1 inputs: right and bottom edges
    assign ax2 = $signed({{2{r_ref_box.x[15]}}, r_ref_box.x}) + $signed({2'b00, r_ref_box.w});
    assign ay2 = $signed({{2{r_ref_box.y[15]}}, r_ref_box.y}) + $signed({2'b00, r_ref_box.h});
    assign bx  = $signed({{2{r_rd_box.x[15]}}, r_rd_box.x});
    assign by  = $signed({{2{r_rd_box.y[15]}}, r_rd_box.y});
    assign bx2 = bx + $signed({2'b00, r_rd_box.w});
    assign by2 = by + $signed({2'b00, r_rd_box.h});

    assign dx = $signed({r_x2[17], r_x2}) - $signed({r_x1[17], r_x1});
    assign dy = $signed({r_y2[17], r_y2}) - $signed({r_y1[17], r_y1});

    assign lhs    = {1'b0, r_inter5, 16'h0000};
    assign d_v    = r_pv[NST-1];
    assign d_idx  = r_pidx[NST-1];
    assign d_mark = r_mark[d_idx];
    assign d_sup  = r_have_ref && !r_uzero5 && (lhs > r_rhs5);

    // store write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_cmem[r_n[IW-1:0]] <= in_box;
            r_smem[r_n[IW-1:0]] <= in_cls;
        end
        r_rd_box <= r_cmem[r_j[IW-1:0]];
        r_rd_cls <= r_smem[r_j[IW-1:0]];
    end

    // overlap datapath
    always_ff @(posedge i_clk) begin
        r_x1 <= (bx > $signed({{2{r_ref_box.x[15]}}, r_ref_box.x})) ? bx
                : $signed({{2{r_ref_box.x[15]}}, r_ref_box.x});
        r_y1 <= (by > $signed({{2{r_ref_box.y[15]}}, r_ref_box.y})) ? by
                : $signed({{2{r_ref_box.y[15]}}, r_ref_box.y});
        r_x2 <= (bx2 < ax2) ? bx2 : ax2;
        r_y2 <= (by2 < ay2) ? by2 : ay2;
        r_iw <= (dx > 0) ? dx[15:0] : 16'h0000;
        r_ih <= (dy > 0) ? dy[15:0] : 16'h0000;
        r_inter3 <= r_iw * r_ih;
        r_ab3    <= r_pbox[2].w * r_pbox[2].h;
        r_uni4   <= {1'b0, r_ref_area} + {1'b0, r_ab3} - {1'b0, r_inter3};
        r_inter4 <= r_inter3;
        r_rhs5   <= {33'd0, r_thr} * {16'd0, r_uni4};
        r_inter5 <= r_inter4;
        r_uzero5 <= (r_uni4 == '0);
        r_pbox[1] <= r_rd_box;
        r_pcls[1] <= r_rd_cls;
        for (int k = 2; k < NST; k++) begin
            r_pbox[k] <= r_pbox[k-1];
            r_pcls[k] <= r_pcls[k-1];
        end
        r_pidx[0] <= r_j[IW-1:0];
        for (int k = 1; k < NST; k++) begin
            r_pidx[k] <= r_pidx[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_thr        <= THR_RESET;
            r_max_kept   <= MAX_KEPT_RESET;
            r_n          <= '0;
            r_ovf        <= 1'b0;
            r_mark       <= '0;
            r_j          <= '0;
            r_kept       <= '0;
            r_have_ref   <= 1'b0;
            r_best_found <= 1'b0;
            r_out_v      <= 1'b0;
            for (int k = 0; k < NST; k++) begin
                r_pv[k] <= 1'b0;
            end
        end else begin
            if (i_cfg.we) begin
                case (i_cfg.idx)
                    CFG_IOU_THR:  r_thr      <= i_cfg.data;
                    CFG_MAX_KEPT: r_max_kept <= i_cfg.data[6:0];
                    default:      r_thr      <= r_thr;
                endcase
            end

            r_pv[0] <= issue;
            for (int k = 1; k < NST; k++) begin
                r_pv[k] <= r_pv[k-1];
            end
            if (r_out_v && !i_stall) begin
                r_out_v <= 1'b0;
            end

            // settle each entry at the end of the pipe: suppress or rank it
            if (d_v && !d_mark) begin
                if (d_sup) begin
                    r_mark[d_idx] <= 1'b1;
                end else if (!r_best_found || (r_pbox[NST-1].score > r_best_box.score)) begin
                    r_best_found <= 1'b1;
                    r_best_box   <= r_pbox[NST-1];
                    r_best_cls   <= r_pcls[NST-1];
                    r_best_idx   <= d_idx;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        if (i_cmd.drop) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_n <= r_n + CW'(1);
                        end
                        if (i_cmd.item.frame_end) begin
                            r_kept       <= '0;
                            r_have_ref   <= 1'b0;
                            r_best_found <= 1'b0;
                            r_j          <= '0;
                            r_state      <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (issue) begin
                        r_j <= r_j + CW'(1);
                    end else if (!pipe_busy) begin
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (!r_have_ref) begin
                        r_ref_box  <= r_best_box;
                        r_ref_cls  <= r_best_cls;
                        r_mark[r_best_idx] <= 1'b1;
                        r_have_ref <= 1'b1;
                        r_state    <= S_AREA;
                    end else begin
                        r_run_end <= !r_best_found || ((r_kept + 7'd1) == lim);
                        r_state   <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_v           <= 1'b1;
                        r_out.kept_x      <= r_ref_box.x;
                        r_out.kept_y      <= r_ref_box.y;
                        r_out.kept_width  <= r_ref_box.w;
                        r_out.kept_height <= r_ref_box.h;
                        r_out.kept_score  <= r_ref_box.score;
                        r_out.kept_class  <= 8'(16'(r_ref_cls));
                        r_out.run_end     <= r_run_end;
                        r_out.overflow    <= r_ovf;
                        r_kept            <= r_kept + 7'd1;
                        if (r_run_end) begin
                            r_mark     <= '0;
                            r_n        <= '0;
                            r_ovf      <= 1'b0;
                            r_have_ref <= 1'b0;
                            r_state    <= S_IDLE;
                        end else begin
                            r_ref_box <= r_best_box;
                            r_ref_cls <= r_best_cls;
                            r_mark[r_best_idx] <= 1'b1;
                            r_state   <= S_AREA;
                        end
                    end
                end
                S_AREA: begin
                    r_ref_area   <= r_ref_box.w * r_ref_box.h;
                    r_best_found <= 1'b0;
                    r_j          <= '0;
                    r_state      <= S_SCAN;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== tb/greedy_box_nms_tb.sv =====
`timescale 1ns / 1ps

module greedy_box_nms_tb;
    import gbn_pkg::*;

    localparam int  STORE_DEPTH = 256;
    localparam int  CYCLE_LIMIT = 1000000;
    localparam int  SETTLE      = 40;

    typedef struct {
        t_in_item  box;
        bit        typed;
        t_out_item want;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_in_item    in_data = '0;
    logic        in_stall;
    logic        out_valid;
    t_out_item   out_data;
    logic        out_stall = 1'b0;
    logic        cfg_we = 1'b0;
    t_cfg_idx    cfg_idx = CFG_IOU_THR;
    logic [15:0] cfg_data = '0;

    // Predictor state: frame store plus our own copy of the registers
    t_in_item    held_box [STORE_DEPTH];
    int          held_cnt;
    bit          held_ovf;
    logic [15:0] thr_reg = THR_RESET;
    logic [6:0]  kept_reg = MAX_KEPT_RESET;

    t_out_item   kept_q[$];
    int          errs = 0;
    int          cycles = 0;
    bit          quiet = 1'b0;      // no idling on either side
    int          hold_cycles = 0;   // long receiver hold-off, counted down by the receiver
    int          stall_left = 0;
    bit          valid_hi = 1'b0;

    t_dir_row    dir_tab [12];

    greedy_box_nms DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("greedy_box_nms_tb: errors");
            $finish;
        end
    end

    function automatic t_in_item mk(int x, int y, int w, int h, int s, int c, bit e);
        t_in_item b;
        b.box_x = x[15:0];
        b.box_y = y[15:0];
        b.box_width = w[15:0];
        b.box_height = h[15:0];
        b.score = s[15:0];
        b.class_id = c[7:0];
        b.frame_end = e;
        return b;
    endfunction

    // IoU over threshold, division free: inter * 2^16 > thr * union
    function automatic bit iou_over(t_in_item a, t_in_item b);
        longint ax, ay, bx, by, aw, ah, bw, bh, x1, y1, x2, y2, iw, ih, inter, uni;
        ax = $signed(a.box_x);  ay = $signed(a.box_y);
        bx = $signed(b.box_x);  by = $signed(b.box_y);
        aw = a.box_width;  ah = a.box_height;
        bw = b.box_width;  bh = b.box_height;
        x1 = (ax > bx) ? ax : bx;
        y1 = (ay > by) ? ay : by;
        x2 = (ax + aw < bx + bw) ? ax + aw : bx + bw;
        y2 = (ay + ah < by + bh) ? ay + ah : by + bh;
        iw = (x2 > x1) ? x2 - x1 : 0;
        ih = (y2 > y1) ? y2 - y1 : 0;
        inter = iw * ih;
        uni = aw * ah + bw * bh - inter;
        if (uni <= 0) return 1'b0;
        return (inter * 65536) > (longint'(thr_reg) * uni);
    endfunction

    // Rank the frame, sweep it greedily and queue the kept boxes
    function automatic void nms_frame_predict();
        int        rank [STORE_DEPTH];
        bit        gone [STORE_DEPTH];
        int        lim, kept, i, j, bi;
        t_out_item r;
        lim = (kept_reg == 0) ? 1 : (kept_reg > RESULT_CAP) ? RESULT_CAP : int'(kept_reg);
        kept = 0;
        for (i = 0; i < held_cnt; i++) begin
            gone[i] = 1'b0;
            j = i;
            while (j > 0 && held_box[rank[j-1]].score < held_box[i].score) begin
                rank[j] = rank[j-1];
                j--;
            end
            rank[j] = i;
        end
        for (i = 0; i < held_cnt && kept < lim; i++) begin
            bi = rank[i];
            if (gone[bi]) continue;
            r.kept_x      = held_box[bi].box_x;
            r.kept_y      = held_box[bi].box_y;
            r.kept_width  = held_box[bi].box_width;
            r.kept_height = held_box[bi].box_height;
            r.kept_score  = held_box[bi].score;
            r.kept_class  = held_box[bi].class_id;
            r.run_end     = 1'b0;
            r.overflow    = held_ovf;
            kept_q = {kept_q, r};
            kept++;
            for (j = i + 1; j < held_cnt; j++)
                if (!gone[rank[j]] && iou_over(held_box[bi], held_box[rank[j]]))
                    gone[rank[j]] = 1'b1;
        end
        if (kept > 0) kept_q[kept_q.size()-1].run_end = 1'b1;
        held_cnt = 0;
        held_ovf = 1'b0;
    endfunction

    function automatic void take_box(t_in_item b);
        if (held_cnt < STORE_DEPTH) begin
            held_box[held_cnt] = b;
            held_cnt++;
        end else begin
            held_ovf = 1'b1;
        end
        if (b.frame_end) nms_frame_predict();
    endfunction

    // Offer one request and hold it until accepted; keep valid up if the
    // next request follows with no gap
    task automatic send_box(t_in_item b);
        int gap;
        if (!valid_hi) begin
            in_valid <= 1'b1;
            valid_hi = 1'b1;
        end
        in_data <= b;
        do @(posedge i_clk); while (in_stall);
        take_box(b);
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            in_valid <= 1'b0;
            valid_hi = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic idle_in();
        if (valid_hi) begin
            in_valid <= 1'b0;
            valid_hi = 1'b0;
        end
    endtask

    // Wait for every kept box, then let the back end settle
    task automatic drain();
        idle_in();
        while (kept_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_IOU_THR) thr_reg = val;
        else kept_reg = val[6:0];
    endtask

    function automatic t_in_item near_box(int cx, int cy, bit last);
        int s;
        s = ($urandom_range(0, 3) == 0) ? 100 * $urandom_range(1, 3) : $urandom_range(0, 65535);
        return mk(cx + $urandom_range(0, 64) - 32, cy + $urandom_range(0, 64) - 32,
                  $urandom_range(16, 240), $urandom_range(16, 240), s,
                  $urandom_range(0, 255), last);
    endfunction

    // One frame: mostly clustered boxes, some pure noise (frame end only on the last box)
    task automatic send_frame(int n);
        int       cx, cy, k;
        t_in_item b;
        cx = $urandom_range(0, 4000) - 2000;
        cy = $urandom_range(0, 4000) - 2000;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 5) == 0) begin
                b = t_in_item'($bits(t_in_item)'({$urandom, $urandom, $urandom}));
                b.frame_end = (k == n - 1);
            end else begin
                b = near_box(cx, cy, k == n - 1);
            end
            send_box(b);
        end
    endtask

    task automatic report(string f, longint e, longint a);
        $display("%0t: %s expected %0d actual %0d", $time, f, e, a);
        errs++;
    endtask

    // Receiver: check every accepted kept box, then pick the next stall
    always @(posedge i_clk) begin
        t_out_item w;
        if (i_rst_n) begin
            if (out_valid && !out_stall) begin
                if (kept_q.size() == 0) begin
                    $display("%0t: unexpected kept box, expected none actual %p",
                             $time, out_data);
                    errs++;
                end else begin
                    w = kept_q.pop_front();
                    if (out_data.kept_x !== w.kept_x)
                        report("kept_x", $signed(w.kept_x), $signed(out_data.kept_x));
                    if (out_data.kept_y !== w.kept_y)
                        report("kept_y", $signed(w.kept_y), $signed(out_data.kept_y));
                    if (out_data.kept_width !== w.kept_width)
                        report("kept_width", w.kept_width, out_data.kept_width);
                    if (out_data.kept_height !== w.kept_height)
                        report("kept_height", w.kept_height, out_data.kept_height);
                    if (out_data.kept_score !== w.kept_score)
                        report("kept_score", w.kept_score, out_data.kept_score);
                    if (out_data.kept_class !== w.kept_class)
                        report("kept_class", w.kept_class, out_data.kept_class);
                    if (out_data.run_end !== w.run_end)
                        report("run_end", w.run_end, out_data.run_end);
                    if (out_data.overflow !== w.overflow)
                        report("overflow", w.overflow, out_data.overflow);
                end
                stall_left = quiet ? 0 : $urandom_range(0, 8);
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin
        int i, p, n;
        // Directed requests: single boxes at the field extremes have a known
        // answer; overlap, tie and zero-area cases go through the predictor
        dir_tab[0] = '{mk(-32768, -32768, 65535, 65535, 65535, 255, 1), 1'b1,
                       t_out_item'({16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                    8'hFF, 1'b1, 1'b0})};
        dir_tab[1] = '{mk(32767, 32767, 0, 0, 0, 0, 1), 1'b1,
                       t_out_item'({16'h7FFF, 16'h7FFF, 16'h0, 16'h0, 16'h0,
                                    8'h0, 1'b1, 1'b0})};
        dir_tab[2]  = '{mk(0, 0, 160, 160, 1000, 1, 0), 1'b0, '0};
        dir_tab[3]  = '{mk(16, 16, 160, 160, 2000, 2, 0), 1'b0, '0};
        dir_tab[4]  = '{mk(800, 800, 160, 160, 2000, 3, 0), 1'b0, '0};
        dir_tab[5]  = '{mk(0, 0, 0, 0, 500, 4, 1), 1'b0, '0};
        dir_tab[6]  = '{mk(5, 5, 0, 0, 100, 5, 0), 1'b0, '0};
        dir_tab[7]  = '{mk(5, 5, 0, 0, 100, 6, 1), 1'b0, '0};
        dir_tab[8]  = '{mk(100, 100, 64, 64, 300, 7, 0), 1'b0, '0};
        dir_tab[9]  = '{mk(100, 100, 64, 64, 300, 8, 1), 1'b0, '0};
        dir_tab[10] = '{mk(-32768, 0, 65535, 16, 40000, 9, 0), 1'b0, '0};
        dir_tab[11] = '{mk(32767, 0, 65535, 16, 40001, 10, 1), 1'b0, '0};

        held_cnt = 0;
        held_ovf = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < 12; i++) begin
            send_box(dir_tab[i].box);
            if (dir_tab[i].typed) kept_q[kept_q.size()-1] = dir_tab[i].want;
        end
        drain();

        // Random phases, each under its own register setting
        for (p = 0; p < 6; p++) begin
            case (p)
                0: begin write_reg(CFG_IOU_THR, 16'd0);     write_reg(CFG_MAX_KEPT, 16'd64); end
                1: begin write_reg(CFG_IOU_THR, 16'd65535); write_reg(CFG_MAX_KEPT, 16'd1);  end
                2: begin write_reg(CFG_IOU_THR, 16'd20000); write_reg(CFG_MAX_KEPT, 16'd0);  end
                3: begin write_reg(CFG_IOU_THR, 16'd50000); write_reg(CFG_MAX_KEPT, 16'd127); end
                4: begin write_reg(CFG_IOU_THR, 16'd32768); write_reg(CFG_MAX_KEPT, 16'd3);  end
                default: begin
                    write_reg(CFG_IOU_THR, THR_RESET);
                    write_reg(CFG_MAX_KEPT, 16'(MAX_KEPT_RESET));
                end
            endcase
            quiet = (p == 3);
            // Hold the result side off so the queue fills and the input stalls
            if (p == 2) hold_cycles = 600;
            n = 0;
            while (n < 26) begin
                i = $urandom_range(1, 8);
                send_frame(i);
                n += i;
            end
            quiet = 1'b0;
            drain();
        end

        if (errs == 0) begin
            $display("greedy_box_nms_tb: clean");
        end else begin
            $display("greedy_box_nms_tb: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/gbn_pkg.sv
rtl/gbn_front.sv
rtl/gbn_fifo.sv
rtl/gbn_back.sv
rtl/greedy_box_nms.sv
tb/greedy_box_nms_tb.sv
